/* hdl/tpf_pkg.sv */
// types, constants and state encoding shared by the fade engine modules
package tpf_pkg;

   localparam int FADE_SLOTS = 32;
   localparam int CHANNELS   = 4;
   localparam int LEVEL_BITS = 10;
   localparam int SLOT_W     = $clog2(FADE_SLOTS);
   localparam int RING_W     = SLOT_W + 1;
   localparam int CH_W       = 2;
   localparam int TICK_W     = 32;
   localparam int DUR_W      = 20;
   localparam int TPS_W      = 10;
   localparam int QM_W       = 10;
   localparam int GPW_W      = 8;
   localparam int PROD_W     = LEVEL_BITS + TICK_W;
   localparam int MS_PROD_W  = DUR_W + TPS_W;
   localparam int CNT_W      = 5;
   localparam int MS_RECIP_W = 31;
   localparam int MS_SHIFT   = 40;
   localparam int MS_WIDE_W  = MS_PROD_W + MS_RECIP_W;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
   // reciprocal of 1000 scaled by 2^40, rounded up
   localparam logic [MS_RECIP_W-1:0] MS_RECIP  = MS_RECIP_W'(1099511628);
   localparam logic [QM_W-1:0]       QM_RESET  = QM_W'(50);
   localparam logic [GPW_W-1:0]      GPW_RESET = GPW_W'(10);
   localparam logic [TPS_W-1:0]      TPS_RESET = TPS_W'(120);

   localparam logic [1:0] CSR_QUIESCE = 2'd0;
   localparam logic [1:0] CSR_GATE_PW = 2'd1;
   localparam logic [1:0] CSR_TPS     = 2'd2;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_ZERO     = 2'd2;

   localparam logic MODE_REQUEST = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [CH_W-1:0]         channel;
      logic [DUR_W-1:0]        duration_ms;
      logic [15:0]             target_level;
   } req_type;

   typedef struct packed {
      logic                    kind;
      logic [1:0]              status;
      logic [CH_W-1:0]         out_channel;
      logic [LEVEL_BITS-1:0]   gate_delay;
      logic                    gate_enable;
      logic                    finished;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [CHANNELS-1:0]     mask;
      logic [LEVEL_BITS-1:0]   start_level;
      logic [LEVEL_BITS-1:0]   end_level;
      logic [TICK_W-1:0]       start_tick;
      logic [TICK_W-1:0]       end_tick;
   } slot_type;

   typedef struct packed {
      logic       load_in;
      logic       q_mul;
      logic       t_mul;
      logic       div_step;
      logic       rd;
      logic       q_eval;
      logic       t_eval;
      logic       t_apply;
      logic       ptr_inc;
      logic       q_write;
      logic       t_finish;
      logic       out_next;
      logic       set_status;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic mode_tick;
      logic ticks_zero;
      logic ring_full;
      logic scan_end;
      logic div_done;
      logic in_window;
      logic last_ch;
   } stat_type;

   typedef enum logic [3:0] {
      S_IDLE, S_Q_MUL, S_Q_DIV, S_Q_CHK, S_Q_RD, S_Q_EV, S_Q_WR, S_R_OUT,
      S_T_RD, S_T_EV, S_T_MUL, S_T_DIV, S_T_APP, S_T_OUT
   } state_type;

endpackage

/* hdl/triac_phase_fade_engine.sv */
// top level of the four-channel phase-angle fade engine
// fade request: duration converted to ticks; rejected if zero ticks or ring full, else the ring is
// scanned for the channel's latest pending fade and the new fade written; then one status item
// tick: each slot in the ring is read, fades in their window pass the 10-step divider, then 4 items
// the engine takes one item at a time; reset (synchronous) empties the ring, zeroes the tick counter,
// sets every channel fully dim with gate enabled and loads the register defaults
module triac_phase_fade_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tpf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [9:0]       csr_data
);

   tpf_pkg::cmd_type  cmd;
   tpf_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   tpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/tpf_ctrl.sv */
// sequencer for fade requests and zero-crossing ticks
module tpf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tpf_pkg::stat_type stat,
   output tpf_pkg::cmd_type  cmd
);

   tpf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         tpf_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = tpf_pkg::S_Q_MUL;
            end
         end
         tpf_pkg::S_Q_MUL: begin
            if (stat.mode_tick) begin
               state_in = tpf_pkg::S_T_RD;
            end else begin
               cmd.q_mul = 1'b1;
               state_in  = tpf_pkg::S_Q_DIV;
            end
         end
         tpf_pkg::S_Q_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = tpf_pkg::S_Q_CHK;
         end
         tpf_pkg::S_Q_CHK: begin
            if (stat.ticks_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = tpf_pkg::ST_ZERO;
               state_in       = tpf_pkg::S_R_OUT;
            end else if (stat.ring_full) begin
               cmd.set_status = 1'b1;
               cmd.status     = tpf_pkg::ST_FULL;
               state_in       = tpf_pkg::S_R_OUT;
            end else begin
               state_in = tpf_pkg::S_Q_RD;
            end
         end
         tpf_pkg::S_Q_RD: begin
            if (stat.scan_end) begin
               state_in = tpf_pkg::S_Q_WR;
            end else begin
               cmd.rd   = 1'b1;
               state_in = tpf_pkg::S_Q_EV;
            end
         end
         tpf_pkg::S_Q_EV: begin
            cmd.q_eval  = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = tpf_pkg::S_Q_RD;
         end
         tpf_pkg::S_Q_WR: begin
            cmd.q_write    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = tpf_pkg::ST_ACCEPTED;
            state_in       = tpf_pkg::S_R_OUT;
         end
         tpf_pkg::S_R_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = tpf_pkg::S_IDLE;
         end
         tpf_pkg::S_T_RD: begin
            if (stat.scan_end) begin
               cmd.t_finish = 1'b1;
               state_in     = tpf_pkg::S_T_OUT;
            end else begin
               cmd.rd   = 1'b1;
               state_in = tpf_pkg::S_T_EV;
            end
         end
         tpf_pkg::S_T_EV: begin
            cmd.t_eval = 1'b1;
            if (stat.in_window) begin
               state_in = tpf_pkg::S_T_MUL;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = tpf_pkg::S_T_RD;
            end
         end
         tpf_pkg::S_T_MUL: begin
            cmd.t_mul = 1'b1;
            state_in  = tpf_pkg::S_T_DIV;
         end
         tpf_pkg::S_T_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = tpf_pkg::S_T_APP;
         end
         tpf_pkg::S_T_APP: begin
            cmd.t_apply = 1'b1;
            cmd.ptr_inc = 1'b1;
            state_in    = tpf_pkg::S_T_RD;
         end
         tpf_pkg::S_T_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.last_ch) begin
                  state_in = tpf_pkg::S_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
               end
            end
         end
         default: state_in = tpf_pkg::S_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("new item taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      cmd.q_write |-> !stat.ring_full)
      else $error("write into full ring");

endmodule

/* hdl/tpf_datapath.sv */
// fade ring, divider, channel state and configuration registers
module tpf_datapath (
   input  logic              clock,
   input  logic              reset,
   input  tpf_pkg::req_type  req_data,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [9:0]        csr_data,
   input  tpf_pkg::cmd_type  cmd,
   output tpf_pkg::stat_type stat,
   output tpf_pkg::rsp_type  rsp_data
);

   localparam int LB = tpf_pkg::LEVEL_BITS;
   localparam int CN = tpf_pkg::CHANNELS;
   localparam int TW = tpf_pkg::TICK_W;
   localparam int RW = tpf_pkg::RING_W;
   localparam int SW = tpf_pkg::SLOT_W;

   tpf_pkg::slot_type          mem [tpf_pkg::FADE_SLOTS];
   tpf_pkg::slot_type          rd_ff;
   tpf_pkg::req_type           in_ff;

   logic [tpf_pkg::QM_W-1:0]   qm_ff;
   logic [tpf_pkg::GPW_W-1:0]  gpw_ff;
   logic [tpf_pkg::TPS_W-1:0]  tps_ff;
   logic [RW-1:0]              head_ff, tail_ff, ptr_ff, newhead_ff;
   logic                       retiring_ff;
   logic [TW-1:0]              tick_ff, cand_ff, el_ff, len_ff;
   logic                       found_ff;
   logic [LB-1:0]              start_lvl_ff, mag_ff;
   logic                       down_ff;
   logic [LB-1:0]              ch_delay_ff [CN];
   logic [CN-1:0]              ch_en_ff, fin_ff;
   logic [tpf_pkg::CH_W-1:0]   out_ch_ff;
   logic [1:0]                 status_ff;

   logic [TW:0]                rem_ff, rem_in, div_r;
   logic [tpf_pkg::PROD_W-1:0] quo_ff, quo_in;
   logic [tpf_pkg::CNT_W-1:0]  cnt_ff;
   logic [TW-1:0]              den;
   logic                       div_ge;

   logic [tpf_pkg::MS_PROD_W-1:0] ms_prod;
   logic [tpf_pkg::MS_WIDE_W-1:0] ms_wide;
   logic [tpf_pkg::PROD_W-1:0]    lvl_prod;
   logic [RW-1:0]              ring_count;
   logic [LB-1:0]              level, raw_delay, delay, target;
   logic                       gate_off;
   tpf_pkg::slot_type          new_slot;

   assign ring_count = tail_ff - head_ff;
   assign ms_prod    = in_ff.duration_ms * tps_ff;
   assign ms_wide    = tpf_pkg::MS_WIDE_W'(quo_ff[tpf_pkg::MS_PROD_W-1:0]) *
                       tpf_pkg::MS_WIDE_W'(tpf_pkg::MS_RECIP);
   assign lvl_prod   = mag_ff * el_ff;
   assign den        = len_ff;
   assign div_r      = {rem_ff[TW-1:0], quo_ff[tpf_pkg::PROD_W-1]};
   assign div_ge     = div_r >= {1'b0, den};
   assign rem_in     = div_ge ? div_r - {1'b0, den} : div_r;
   assign quo_in     = {quo_ff[tpf_pkg::PROD_W-2:0], div_ge};

   assign target = (in_ff.target_level > 16'(tpf_pkg::LEVEL_MAX)) ?
                   tpf_pkg::LEVEL_MAX : in_ff.target_level[LB-1:0];

   always_comb begin
      new_slot             = '0;
      new_slot.mask        = CN'(1) << in_ff.channel;
      new_slot.start_level = found_ff ? start_lvl_ff :
                             tpf_pkg::LEVEL_MAX - ch_delay_ff[in_ff.channel];
      new_slot.end_level   = target;
      new_slot.start_tick  = tick_ff;
      new_slot.end_tick    = tick_ff + TW'(quo_ff[tpf_pkg::MS_PROD_W-1:0]);
   end

   always_comb begin
      if (len_ff == '0) level = rd_ff.end_level;
      else if (down_ff) level = rd_ff.start_level - quo_ff[LB-1:0];
      else              level = rd_ff.start_level + quo_ff[LB-1:0];
      raw_delay = tpf_pkg::LEVEL_MAX - level;
      delay     = (raw_delay < qm_ff) ? qm_ff : raw_delay;
      gate_off  = ({1'b0, delay} + (LB+1)'(gpw_ff)) >= {1'b0, tpf_pkg::LEVEL_MAX};
   end

   always_comb begin
      stat.mode_tick  = in_ff.mode == tpf_pkg::MODE_TICK;
      stat.ticks_zero = quo_ff[tpf_pkg::MS_PROD_W-1:0] == '0;
      stat.ring_full  = ring_count[RW-1];
      stat.scan_end   = ptr_ff == tail_ff;
      stat.div_done   = cnt_ff == '0;
      stat.in_window  = (rd_ff.start_tick <= tick_ff) && (tick_ff <= rd_ff.end_tick);
      stat.last_ch    = out_ch_ff == tpf_pkg::CH_W'(CN - 1);
   end

   always_comb begin
      rsp_data = '0;
      if (in_ff.mode == tpf_pkg::MODE_TICK) begin
         rsp_data.kind        = 1'b1;
         rsp_data.out_channel = out_ch_ff;
         rsp_data.gate_delay  = ch_delay_ff[out_ch_ff];
         rsp_data.gate_enable = ch_en_ff[out_ch_ff];
         rsp_data.finished    = fin_ff[out_ch_ff];
         rsp_data.last        = stat.last_ch;
      end else begin
         rsp_data.status      = status_ff;
         rsp_data.out_channel = in_ff.channel;
         rsp_data.last        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_write) mem[tail_ff[SW-1:0]] <= new_slot;
      if (cmd.rd) rd_ff <= mem[ptr_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qm_ff    <= tpf_pkg::QM_RESET;
         gpw_ff   <= tpf_pkg::GPW_RESET;
         tps_ff   <= tpf_pkg::TPS_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         tick_ff  <= '0;
         ch_en_ff <= '1;
         for (int c = 0; c < CN; c++) ch_delay_ff[c] <= tpf_pkg::LEVEL_MAX;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               tpf_pkg::CSR_QUIESCE: qm_ff  <= csr_data;
               tpf_pkg::CSR_GATE_PW: gpw_ff <= csr_data[tpf_pkg::GPW_W-1:0];
               tpf_pkg::CSR_TPS:     tps_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.q_write) tail_ff <= tail_ff + 1'b1;
         if (cmd.t_finish) begin
            head_ff <= newhead_ff;
            tick_ff <= tick_ff + 1'b1;
         end
         if (cmd.t_apply) begin
            for (int c = 0; c < CN; c++) begin
               if (rd_ff.mask[c]) begin
                  if (gate_off) begin
                     ch_en_ff[c] <= 1'b0;
                  end else begin
                     ch_en_ff[c]    <= 1'b1;
                     ch_delay_ff[c] <= delay;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff       <= req_data;
         ptr_ff      <= head_ff;
         newhead_ff  <= head_ff;
         retiring_ff <= 1'b1;
         cand_ff     <= tick_ff;
         found_ff    <= 1'b0;
         fin_ff      <= '0;
         out_ch_ff   <= '0;
      end
      if (cmd.ptr_inc) ptr_ff <= ptr_ff + 1'b1;
      if (cmd.out_next) out_ch_ff <= out_ch_ff + 1'b1;
      if (cmd.set_status) status_ff <= cmd.status;
      if (cmd.q_eval) begin
         if (((rd_ff.mask >> in_ff.channel) & CN'(1)) != '0 && rd_ff.end_tick >= cand_ff) begin
            start_lvl_ff <= rd_ff.end_level;
            cand_ff      <= rd_ff.end_tick;
            found_ff     <= 1'b1;
         end
      end
      if (cmd.t_eval) begin
         el_ff   <= tick_ff - rd_ff.start_tick;
         len_ff  <= rd_ff.end_tick - rd_ff.start_tick;
         down_ff <= rd_ff.end_level < rd_ff.start_level;
         mag_ff  <= (rd_ff.end_level < rd_ff.start_level) ?
                    rd_ff.start_level - rd_ff.end_level :
                    rd_ff.end_level - rd_ff.start_level;
         if (retiring_ff && rd_ff.end_tick <= tick_ff) newhead_ff <= ptr_ff + 1'b1;
         else retiring_ff <= 1'b0;
         if (rd_ff.end_tick == tick_ff) fin_ff <= fin_ff | rd_ff.mask;
      end
      if (cmd.q_mul) begin
         rem_ff <= '0;
         quo_ff <= tpf_pkg::PROD_W'(ms_prod);
         cnt_ff <= '0;
      end else if (cmd.t_mul) begin
         rem_ff <= {1'b0, lvl_prod[tpf_pkg::PROD_W-1:LB]};
         quo_ff <= {lvl_prod[LB-1:0], {TW{1'b0}}};
         cnt_ff <= tpf_pkg::CNT_W'(LB - 1);
      end else if (cmd.div_step) begin
         if (in_ff.mode == tpf_pkg::MODE_TICK) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end else begin
            // milliseconds to ticks by reciprocal multiplication
            quo_ff <= tpf_pkg::PROD_W'(ms_wide[tpf_pkg::MS_WIDE_W-1:tpf_pkg::MS_SHIFT]);
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (RW+1)'(ring_count) <= (RW+1)'(tpf_pkg::FADE_SLOTS))
      else $error("ring occupancy beyond slot count");
   assert property (@(posedge clock) disable iff (reset)
      cmd.t_finish |=> tick_ff == $past(tick_ff) + 1'b1)
      else $error("tick counter did not advance");
   assert property (@(posedge clock) disable iff (reset)
      cmd.t_apply && len_ff != '0 |-> quo_ff[LB-1:0] <= mag_ff)
      else $error("interpolation step beyond level span");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the four-channel triac fade engine
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SLOTS       = tpf_pkg::FADE_SLOTS;
   localparam int CHS         = tpf_pkg::CHANNELS;
   localparam int LB          = tpf_pkg::LEVEL_BITS;
   localparam int SW          = tpf_pkg::SLOT_W;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tpf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tpf_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = tpf_pkg::CSR_QUIESCE;
   logic [9:0]       csr_data = '0;

   triac_phase_fade_engine DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the fade ring and channel outputs
   logic [CHS-1:0]                fade_mask [SLOTS];
   logic [LB-1:0]                 fade_from [SLOTS];
   logic [LB-1:0]                 fade_to   [SLOTS];
   logic [31:0]                   fade_t0   [SLOTS];
   logic [31:0]                   fade_t1   [SLOTS];
   logic [tpf_pkg::RING_W-1:0]    ring_rd, ring_wr;
   logic [31:0]                   tick_now;
   logic [LB-1:0]                 ch_delay [CHS];
   logic                          ch_gate  [CHS];
   logic [tpf_pkg::QM_W-1:0]      margin;
   logic [tpf_pkg::GPW_W-1:0]     pulse_w;
   logic [tpf_pkg::TPS_W-1:0]     half_cycles;

   tpf_pkg::rsp_type expected_rsp [$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      rsp_checked = 0;
   int      ticks_sent = 0;
   int      full_seen = 0;
   int      cycles = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      hold_left = 0;

   function automatic tpf_pkg::rsp_type make_rsp(logic kind, logic [1:0] st, logic [1:0] ch,
                                                 logic [9:0] dly, logic en, logic fin,
                                                 logic lst);
      tpf_pkg::rsp_type r;
      r.kind = kind; r.status = st; r.out_channel = ch; r.gate_delay = dly;
      r.gate_enable = en; r.finished = fin; r.last = lst;
      return r;
   endfunction

   function automatic void queue_fade(tpf_pkg::req_type r);
      logic [1:0]                 ch;
      logic [LB-1:0]              target, from;
      longint unsigned            ticks;
      logic [tpf_pkg::RING_W-1:0] i, pending;
      logic [31:0]                cand;
      bit                         found;
      logic [1:0]                 st;
      ch = r.channel;
      target = (r.target_level > tpf_pkg::LEVEL_MAX) ? tpf_pkg::LEVEL_MAX :
               r.target_level[LB-1:0];
      ticks = (longint'(r.duration_ms) * longint'(half_cycles)) / 1000;
      pending = ring_wr - ring_rd;
      if (ticks[31:0] == 0) st = tpf_pkg::ST_ZERO;
      else if (pending >= SLOTS) st = tpf_pkg::ST_FULL;
      else begin
         st = tpf_pkg::ST_ACCEPTED;
         found = 0; from = '0; cand = tick_now;
         for (i = ring_rd; i != ring_wr; i++) begin
            if (fade_mask[i[SW-1:0]][ch] && fade_t1[i[SW-1:0]] >= cand) begin
               from = fade_to[i[SW-1:0]];
               cand = fade_t1[i[SW-1:0]];
               found = 1;
            end
         end
         if (!found) from = tpf_pkg::LEVEL_MAX - ch_delay[ch];
         fade_mask[ring_wr[SW-1:0]] = CHS'(1) << ch;
         fade_from[ring_wr[SW-1:0]] = from;
         fade_to[ring_wr[SW-1:0]]   = target;
         fade_t0[ring_wr[SW-1:0]]   = tick_now;
         fade_t1[ring_wr[SW-1:0]]   = tick_now + ticks[31:0];
         ring_wr++;
      end
      if (st == tpf_pkg::ST_FULL) full_seen++;
      expected_rsp.push_back(make_rsp(1'b0, st, ch, '0, 1'b0, 1'b0, 1'b1));
   endfunction

   function automatic void advance_tick();
      logic [31:0]                t, len, el;
      logic [tpf_pkg::RING_W-1:0] i, old_rd;
      logic [SW-1:0]              s;
      longint                     lvl, dly;
      bit                         fin [CHS];
      t = tick_now;
      foreach (fin[c]) fin[c] = 0;
      for (i = ring_rd; i != ring_wr; i++) begin
         s = i[SW-1:0];
         if (fade_t0[s] <= t && t <= fade_t1[s]) begin
            len = fade_t1[s] - fade_t0[s];
            el  = t - fade_t0[s];
            if (len == 0) lvl = fade_to[s];
            else lvl = longint'(fade_from[s]) + (longint'(fade_to[s]) - longint'(fade_from[s]))
                       * longint'(el) / longint'(len);
            if (lvl < 0) lvl = 0;
            if (lvl > tpf_pkg::LEVEL_MAX) lvl = tpf_pkg::LEVEL_MAX;
            dly = longint'(tpf_pkg::LEVEL_MAX) - lvl;
            if (dly < margin) dly = margin;
            for (int c = 0; c < CHS; c++) begin
               if (fade_mask[s][c]) begin
                  if (dly + pulse_w >= tpf_pkg::LEVEL_MAX) ch_gate[c] = 1'b0;
                  else begin
                     ch_delay[c] = dly[LB-1:0];
                     ch_gate[c] = 1'b1;
                  end
               end
            end
         end
      end
      old_rd = ring_rd;
      while (ring_rd != ring_wr && fade_t1[ring_rd[SW-1:0]] <= t) ring_rd++;
      for (i = old_rd; i != ring_wr; i++)
         if (fade_t1[i[SW-1:0]] == t)
            for (int c = 0; c < CHS; c++)
               if (fade_mask[i[SW-1:0]][c]) fin[c] = 1;
      tick_now = t + 1;
      for (int c = 0; c < CHS; c++)
         expected_rsp.push_back(make_rsp(1'b1, tpf_pkg::ST_ACCEPTED, c[1:0], ch_delay[c],
                                         ch_gate[c], fin[c], c == CHS - 1));
   endfunction

   initial begin
      ring_rd = '0; ring_wr = '0; tick_now = '0;
      foreach (ch_delay[c]) begin
         ch_delay[c] = tpf_pkg::LEVEL_MAX;
         ch_gate[c] = 1'b1;
      end
      margin = tpf_pkg::QM_RESET; pulse_w = tpf_pkg::GPW_RESET; half_cycles = tpf_pkg::TPS_RESET;
   end

   // result checker
   always @(negedge clock) begin
      tpf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_checked++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %p", rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.status !== want.status ||
                rsp_data.out_channel !== want.out_channel ||
                rsp_data.gate_delay !== want.gate_delay ||
                rsp_data.gate_enable !== want.gate_enable ||
                rsp_data.finished !== want.finished || rsp_data.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at tick %0d: expected %p, got %p", tick_now, want, rsp_data);
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_item(tpf_pkg::req_type r);
      bit taken;
      req_valid <= 1'b1;
      req_data <= r;
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      items_sent++;
      if (r.mode == tpf_pkg::MODE_TICK) begin
         ticks_sent++;
         advance_tick();
      end else begin
         queue_fade(r);
      end
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_tick();
      tpf_pkg::req_type r;
      r = '0;
      r.mode = tpf_pkg::MODE_TICK;
      r.duration_ms = tpf_pkg::DUR_W'($urandom());
      r.channel = tpf_pkg::CH_W'($urandom());
      r.target_level = 16'($urandom());
      send_item(r);
   endtask

   task automatic send_fade(int ch, int ms, int lvl);
      tpf_pkg::req_type r;
      r.mode = tpf_pkg::MODE_REQUEST;
      r.channel = ch[tpf_pkg::CH_W-1:0];
      r.duration_ms = ms[tpf_pkg::DUR_W-1:0];
      r.target_level = lvl[15:0];
      send_item(r);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[9:0];
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      case (idx)
         tpf_pkg::CSR_QUIESCE: margin = value[tpf_pkg::QM_W-1:0];
         tpf_pkg::CSR_GATE_PW: pulse_w = value[tpf_pkg::GPW_W-1:0];
         tpf_pkg::CSR_TPS:     half_cycles = value[tpf_pkg::TPS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(int qm, int gpw, int tps);
      wait_drained();
      write_reg(tpf_pkg::CSR_QUIESCE, qm);
      write_reg(tpf_pkg::CSR_GATE_PW, gpw);
      write_reg(tpf_pkg::CSR_TPS, tps);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item(int max_ms);
      int lvl;
      if ($urandom_range(99) < 40) send_tick();
      else begin
         case ($urandom_range(3))
            0: lvl = $urandom_range(0, 65535);
            1: lvl = $urandom_range(0, 40);
            2: lvl = $urandom_range(980, 1023);
            default: lvl = $urandom_range(0, 1023);
         endcase
         send_fade($urandom_range(0, 3), $urandom_range(0, max_ms), lvl);
      end
   endtask

   task automatic test_directed();
      send_fade(0, 0, 500);
      send_fade(1, 8, 500);
      send_fade(0, 50, 1023);
      send_fade(0, 25, 0);
      send_fade(1, 9, 65535);
      send_fade(2, 40, 1024);
      send_fade(3, 30, 0);
      repeat (3) send_tick();
      send_fade(2, 20, 700);
      repeat (8) send_tick();
      send_fade(3, 17, 1023);
      repeat (4) send_tick();
   endtask

   task automatic test_ring_full();
      wait_drained();
      for (int k = 0; k < SLOTS + 2; k++) send_fade(k % CHS, 40, $urandom_range(0, 1023));
      repeat (8) send_tick();
   endtask

   task automatic test_settings();
      set_regs(0, 1, 1);
      send_fade(1, 999, 300);
      send_fade(1, 1000, 1023);
      repeat (3) send_tick();
      set_regs(1023, 255, 1023);
      send_fade(2, 3, 900);
      send_fade(0, 1, 100);
      repeat (4) send_tick();
      set_regs(600, 200, 0);
      send_fade(3, 1048575, 800);
      send_tick();
      set_regs(0, 255, 240);
      for (int k = 0; k < 12; k++) random_item(80);
      set_regs(tpf_pkg::QM_RESET, tpf_pkg::GPW_RESET, tpf_pkg::TPS_RESET);
   endtask

   task automatic test_idling();
      int pct [4][2] = '{'{0, 0}, '{62, 0}, '{0, 62}, '{8, 8}};
      for (int p = 0; p < 4; p++) begin
         idle_pct = pct[p][0];
         stall_pct = pct[p][1];
         for (int k = 0; k < 28; k++) random_item(200);
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_left = 3000;
      send_fade(1, 100, 1000);
      repeat (8) send_tick();
   endtask

   task automatic test_long_fades();
      tpf_pkg::req_type r;
      set_regs($urandom_range(0, 100), $urandom_range(1, 255), 1023);
      for (int k = 0; k < 10; k++) begin
         r = '0;
         r.mode = tpf_pkg::MODE_REQUEST;
         r.channel = tpf_pkg::CH_W'($urandom());
         r.duration_ms = tpf_pkg::DUR_W'($urandom());
         r.target_level = 16'($urandom());
         send_item(r);
         send_tick();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_ring_full();
      test_settings();
      test_idling();
      test_backpressure();
      test_long_fades();
      wait_drained();
      repeat (50) @(posedge clock);
      $display("%0d items sent (%0d ticks), %0d results checked, %0d ring-full drops",
               items_sent, ticks_sent, rsp_checked, full_seen);
      $display("covered register extremes, idle and stall mixes, a long receiver hold-off");
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("Test completed successfully");
      else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_rsp.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
